@@ hw/rtl/lars_pkg.sv @@
`timescale 1ns / 1ps

package lars_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_ELEMENTS_LOG2_DEF = 20;
    localparam int CFG_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int SUM_WIDTH = 64;
    localparam int SQRT_COUNT_WIDTH = 6;
    localparam int DIV_COUNT_WIDTH = 7;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEARNING_RATE = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MOMENTUM_COEF = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WEIGHT_DECAY = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TRUST_COEF = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EPSILON_TERM = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GRAD_SCALE = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NESTEROV_ENABLE = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LAYER_SCALING_ENABLE = 3'd7;

    typedef struct packed {
        logic                             req_type;
        logic signed [DATA_WIDTH_DEF-1:0] weight_in;
        logic signed [DATA_WIDTH_DEF-1:0] grad_in;
        logic signed [DATA_WIDTH_DEF-1:0] velocity_in;
        logic                             last_element;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_WIDTH_DEF-1:0] weight_out;
        logic signed [DATA_WIDTH_DEF-1:0] velocity_out;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ACC,
        ST_SQRT,
        ST_DEN,
        ST_DIV,
        ST_RATIO,
        ST_UPD_U,
        ST_UPD_S,
        ST_UPD_V,
        ST_UPD_N,
        ST_UPD_W,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic scale;
        logic acc;
        logic sqrt_start;
        logic sqrt_step;
        logic den;
        logic div_step;
        logic ratio;
        logic upd_u;
        logic upd_s;
        logic upd_v;
        logic upd_n;
        logic upd_w;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic req_type;
        logic last_element;
        logic sqrt_done;
        logic div_done;
        logic nesterov;
        logic out_full;
    } status_t;

endpackage

@@ hw/rtl/lars_ctrl.sv @@
`timescale 1ns / 1ps

module lars_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lars_pkg::status_t  status,
    output lars_pkg::cmd_t     cmd
);

    lars_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lars_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lars_pkg::ST_IDLE: begin
                if (s_valid) state_next = lars_pkg::ST_SCALE;
            end
            lars_pkg::ST_SCALE: begin
                state_next = status.req_type ? lars_pkg::ST_UPD_U : lars_pkg::ST_ACC;
            end
            lars_pkg::ST_ACC: begin
                state_next = status.last_element ? lars_pkg::ST_SQRT : lars_pkg::ST_IDLE;
            end
            lars_pkg::ST_SQRT: begin
                if (status.sqrt_done) state_next = lars_pkg::ST_DEN;
            end
            lars_pkg::ST_DEN: state_next = lars_pkg::ST_DIV;
            lars_pkg::ST_DIV: begin
                if (status.div_done) state_next = lars_pkg::ST_RATIO;
            end
            lars_pkg::ST_RATIO: state_next = lars_pkg::ST_IDLE;
            lars_pkg::ST_UPD_U: state_next = lars_pkg::ST_UPD_S;
            lars_pkg::ST_UPD_S: state_next = lars_pkg::ST_UPD_V;
            lars_pkg::ST_UPD_V: begin
                state_next = status.nesterov ? lars_pkg::ST_UPD_N : lars_pkg::ST_UPD_W;
            end
            lars_pkg::ST_UPD_N: state_next = lars_pkg::ST_UPD_W;
            lars_pkg::ST_UPD_W: state_next = lars_pkg::ST_OUT;
            lars_pkg::ST_OUT: begin
                if (!status.out_full) state_next = lars_pkg::ST_IDLE;
            end
            default: state_next = lars_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            lars_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                cmd.load = s_valid;
            end
            lars_pkg::ST_SCALE: cmd.scale = 1'b1;
            lars_pkg::ST_ACC: begin
                cmd.acc = 1'b1;
                cmd.sqrt_start = status.last_element;
            end
            lars_pkg::ST_SQRT: cmd.sqrt_step = 1'b1;
            lars_pkg::ST_DEN: cmd.den = 1'b1;
            lars_pkg::ST_DIV: cmd.div_step = 1'b1;
            lars_pkg::ST_RATIO: cmd.ratio = 1'b1;
            lars_pkg::ST_UPD_U: cmd.upd_u = 1'b1;
            lars_pkg::ST_UPD_S: cmd.upd_s = 1'b1;
            lars_pkg::ST_UPD_V: cmd.upd_v = 1'b1;
            lars_pkg::ST_UPD_N: cmd.upd_n = 1'b1;
            lars_pkg::ST_UPD_W: cmd.upd_w = 1'b1;
            lars_pkg::ST_OUT: cmd.out_load = !status.out_full;
            default: cmd = '0;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == lars_pkg::ST_SCALE))
        else $error("accepted word did not start processing");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lars_pkg::ST_SQRT && !status.sqrt_done) |=> (state_reg == lars_pkg::ST_SQRT))
        else $error("square root left early");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (state_reg == lars_pkg::ST_OUT && !status.out_full))
        else $error("result loaded into a full output register");

endmodule

@@ hw/rtl/lars_datapath.sv @@
`timescale 1ns / 1ps

module lars_datapath #(
    parameter int FRAC_BITS = lars_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lars_pkg::in_word_t                 s_word,
    input  logic                               cfg_we,
    input  logic [lars_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [lars_pkg::CFG_WIDTH-1:0]     cfg_data,
    input  lars_pkg::cmd_t                     cmd,
    output lars_pkg::status_t                  status,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lars_pkg::out_word_t                m_word
);

    localparam int DW = lars_pkg::DATA_WIDTH_DEF;
    localparam int SW = lars_pkg::SUM_WIDTH;
    localparam int AW = 64 - FRAC_BITS;
    localparam logic signed [DW:0] SMAX = (DW+1)'((65'sd1 <<< (DW - 1)) - 1);
    localparam logic signed [DW:0] SMIN = -SMAX - 1;
    localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);

    logic [31:0] lr_reg, mom_reg, decay_reg, trust_reg, eps_reg, gscale_reg;
    logic nest_reg, lse_reg;
    logic [31:0] ratio_reg;
    logic [SW-1:0] wsum_reg, gsum_reg;
    logic req_reg, last_reg;
    logic signed [DW-1:0] w_reg, g_reg, v_reg, gs_reg, u_reg, s_reg, vn_reg, step_reg;
    logic [AW-1:0] ar_reg;
    logic out_valid_reg;
    lars_pkg::out_word_t out_reg;

    // Signed value times unsigned Q factor, truncated toward zero, saturated.
    function automatic logic signed [DW-1:0] fx_mul(input logic signed [DW-1:0] a,
                                                    input logic [31:0] b);
        logic neg;
        logic [DW-1:0] mag;
        logic [DW+31:0] p;
        logic [DW+31:0] r;
        logic [DW+31:0] lim;
        begin
            neg = a[DW-1];
            mag = neg ? DW'(-a) : DW'(a);
            p = (DW+32)'(mag) * (DW+32)'(b);
            r = p >> FRAC_BITS;
            lim = neg ? (DW+32)'(SMAX) + 1'b1 : (DW+32)'(SMAX);
            if (r > lim) r = lim;
            fx_mul = neg ? DW'(-r) : DW'(r);
        end
    endfunction

    // The scaled rate is wider than 32 bits, so its product is built from a low
    // and a high partial product.
    function automatic logic signed [DW-1:0] fx_mul_rate(input logic signed [DW-1:0] a,
                                                         input logic [AW-1:0] b);
        logic neg;
        logic [DW-1:0] mag;
        logic [DW+AW-1:0] p;
        logic [DW+AW-1:0] r;
        logic [DW+AW-1:0] lim;
        begin
            neg = a[DW-1];
            mag = neg ? DW'(-a) : DW'(a);
            p = (DW+AW)'((DW+32)'(mag) * (DW+32)'(b[31:0]))
                + ((DW+AW)'((DW+AW-32)'(mag) * (DW+AW-32)'(b[AW-1:32])) << 32);
            r = p >> FRAC_BITS;
            lim = neg ? (DW+AW)'(SMAX) + 1'b1 : (DW+AW)'(SMAX);
            if (r > lim) r = lim;
            fx_mul_rate = neg ? DW'(-r) : DW'(r);
        end
    endfunction

    function automatic logic signed [DW-1:0] sat(input logic signed [DW+1:0] x);
        begin
            if (x > (DW+2)'(SMAX)) sat = DW'(SMAX);
            else if (x < (DW+2)'(SMIN)) sat = DW'(SMIN);
            else sat = DW'(x);
        end
    endfunction

    function automatic logic [SW-1:0] sq_sat(input logic signed [DW-1:0] a);
        logic [DW-1:0] mag;
        logic [2*DW-1:0] p;
        begin
            mag = a[DW-1] ? DW'(-a) : DW'(a);
            p = (2*DW)'(mag) * (2*DW)'(mag);
            if (2 * DW > SW && (p >> SW) != 0) sq_sat = '1;
            else sq_sat = SW'(p);
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg <= 32'd655;
            mom_reg <= 32'd58982;
            decay_reg <= 32'd0;
            trust_reg <= 32'd66;
            eps_reg <= 32'd1;
            gscale_reg <= 32'd65536;
            nest_reg <= 1'b0;
            lse_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                lars_pkg::REG_LEARNING_RATE: lr_reg <= cfg_data;
                lars_pkg::REG_MOMENTUM_COEF: mom_reg <= cfg_data;
                lars_pkg::REG_WEIGHT_DECAY: decay_reg <= cfg_data;
                lars_pkg::REG_TRUST_COEF: trust_reg <= cfg_data;
                lars_pkg::REG_EPSILON_TERM: eps_reg <= cfg_data;
                lars_pkg::REG_GRAD_SCALE: gscale_reg <= cfg_data;
                lars_pkg::REG_NESTEROV_ENABLE: nest_reg <= cfg_data[0];
                lars_pkg::REG_LAYER_SCALING_ENABLE: lse_reg <= cfg_data[0];
                default: lr_reg <= lr_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_word.req_type;
            last_reg <= s_word.last_element;
            w_reg <= DW'(s_word.weight_in);
            g_reg <= DW'(s_word.grad_in);
            v_reg <= DW'(s_word.velocity_in);
        end
        if (cmd.scale) begin
            gs_reg <= fx_mul(g_reg, gscale_reg);
            ar_reg <= AW'(((64'(lr_reg) * 64'(ratio_reg)) >> FRAC_BITS));
        end
        if (cmd.upd_u) u_reg <= sat((DW+2)'(gs_reg) + (DW+2)'(fx_mul(w_reg, decay_reg)));
        if (cmd.upd_s) s_reg <= fx_mul_rate(u_reg, ar_reg);
        if (cmd.upd_v) begin
            vn_reg <= sat((DW+2)'(fx_mul(v_reg, mom_reg)) + (DW+2)'(s_reg));
            step_reg <= sat((DW+2)'(fx_mul(v_reg, mom_reg)) + (DW+2)'(s_reg));
        end
        if (cmd.upd_n) step_reg <= sat((DW+2)'(fx_mul(vn_reg, mom_reg)) + (DW+2)'(s_reg));
        // The output register is only loaded once the previous word has gone.
        if (cmd.out_load) begin
            out_reg.weight_out <= DW'(sat((DW+2)'(w_reg) - (DW+2)'(step_reg)));
            out_reg.velocity_out <= DW'(vn_reg);
        end
    end

    // Saturating sums, cleared by the last update word.
    logic [SW:0] wadd, gadd;
    assign wadd = (SW+1)'(wsum_reg) + (SW+1)'(sq_sat(w_reg));
    assign gadd = (SW+1)'(gsum_reg) + (SW+1)'(sq_sat(gs_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsum_reg <= '0;
            gsum_reg <= '0;
        end else if (cmd.acc) begin
            wsum_reg <= wadd[SW] ? '1 : wadd[SW-1:0];
            gsum_reg <= gadd[SW] ? '1 : gadd[SW-1:0];
        end else if (cmd.upd_w && last_reg) begin
            wsum_reg <= '0;
            gsum_reg <= '0;
        end
    end

    // Two digit-by-digit square roots running together, one result bit a cycle.
    logic [SW-1:0] wrem_reg, grem_reg, wroot_reg, groot_reg;
    logic [SW-1:0] wrem_acc, grem_acc;
    logic [lars_pkg::SQRT_COUNT_WIDTH-1:0] sq_cnt_reg;
    logic [SW+1:0] wtrial, gtrial;
    logic [SW-1:0] wbit, gbit;
    assign wrem_acc = wadd[SW] ? '1 : wadd[SW-1:0];
    assign grem_acc = gadd[SW] ? '1 : gadd[SW-1:0];
    assign wbit = SW'(1) << (2 * sq_cnt_reg);
    assign gbit = wbit;
    assign wtrial = (SW+2)'(wroot_reg) + (SW+2)'(wbit);
    assign gtrial = (SW+2)'(groot_reg) + (SW+2)'(gbit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_cnt_reg <= '0;
        end else if (cmd.sqrt_start) begin
            wrem_reg <= wrem_acc;
            grem_reg <= grem_acc;
            wroot_reg <= '0;
            groot_reg <= '0;
            sq_cnt_reg <= 6'd31;
        end else if (cmd.sqrt_step && sq_cnt_reg != 6'd63) begin
            if ((SW+2)'(wrem_reg) >= wtrial) begin
                wrem_reg <= wrem_reg - SW'(wtrial);
                wroot_reg <= (wroot_reg >> 1) + wbit;
            end else begin
                wroot_reg <= wroot_reg >> 1;
            end
            if ((SW+2)'(grem_reg) >= gtrial) begin
                grem_reg <= grem_reg - SW'(gtrial);
                groot_reg <= (groot_reg >> 1) + gbit;
            end else begin
                groot_reg <= groot_reg >> 1;
            end
            sq_cnt_reg <= sq_cnt_reg - 1'b1;
        end
    end

    // Restoring divider, one quotient bit a cycle.
    logic [SW-1:0] num_reg, quo_reg;
    logic [SW:0] den_reg, rem_reg;
    logic [lars_pkg::DIV_COUNT_WIDTH-1:0] div_cnt_reg;
    logic [SW:0] rem_shift;
    assign rem_shift = {rem_reg[SW-1:0], num_reg[SW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.den) begin
            num_reg <= 64'(trust_reg) * 64'(wroot_reg[31:0]);
            den_reg <= (SW+1)'(groot_reg) + (SW+1)'((64'(decay_reg) * 64'(wroot_reg[31:0]))
                       >> FRAC_BITS) + (SW+1)'(eps_reg);
            rem_reg <= '0;
            quo_reg <= '0;
            div_cnt_reg <= 7'd64;
        end else if (cmd.div_step && div_cnt_reg != 0) begin
            num_reg <= num_reg << 1;
            if (rem_shift >= den_reg) begin
                rem_reg <= rem_shift - den_reg;
                quo_reg <= {quo_reg[SW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[SW-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // With a zero divisor the remainder ends up holding the whole numerator.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg <= ONE_FX;
        end else if (cmd.ratio) begin
            if (!lse_reg) ratio_reg <= ONE_FX;
            else if (den_reg == 0) ratio_reg <= (rem_reg == 0) ? '0 : '1;
            else if (quo_reg[SW-1:32] != 0) ratio_reg <= '1;
            else ratio_reg <= quo_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word = out_reg;
    assign status.req_type = req_reg;
    assign status.last_element = last_reg;
    assign status.sqrt_done = (sq_cnt_reg == 6'd63);
    assign status.div_done = (div_cnt_reg == 0);
    assign status.nesterov = nest_reg;
    assign status.out_full = out_valid_reg && !m_ready;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before it was taken");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ratio |-> status.div_done)
        else $error("ratio taken before the division finished");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.upd_w && last_reg) |=> (wsum_reg == 0 && gsum_reg == 0))
        else $error("sums not cleared after the last update word");

endmodule

@@ hw/rtl/lars_optimizer_update.sv @@
`timescale 1ns / 1ps

// LARS optimiser element engine. Accumulate words (req_type 0) give no
// result; the last one also runs two 32-step square roots and a 64-step
// divider before the next word is taken. Update words pass through the
// chain of registered multipliers in the datapath, with an extra step
// when Nesterov is on, and may then wait on m_ready.
module lars_optimizer_update #(
    parameter int FRAC_BITS = lars_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  lars_pkg::in_word_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output lars_pkg::out_word_t                  m_data,
    input  logic                                 cfg_we,
    input  logic [lars_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [lars_pkg::CFG_WIDTH-1:0]       cfg_data
);

    lars_pkg::cmd_t cmd;
    lars_pkg::status_t status;

    lars_ctrl u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .status(status),
        .cmd(cmd)
    );

    lars_datapath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_datapath (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_word(s_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cmd(cmd),
        .status(status),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_word(m_data)
    );

endmodule
